### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/vvrf_pkg.sv
package vvrf_pkg;

    localparam int DIM_W    = 9;
    localparam int COORD_W  = 8;
    localparam int IDX_W    = 24;
    localparam int VOXEL_W  = 10;
    localparam int PLANE_W  = 2 * DIM_W - 1;
    localparam int CODE_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = DIM_W;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 88;

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM = 3'd6;

    localparam logic [CODE_W-1:0] XF_IDENTITY = 4'd0;
    localparam logic [CODE_W-1:0] XF_ROT_X90  = 4'd1;
    localparam logic [CODE_W-1:0] XF_ROT_X180 = 4'd2;
    localparam logic [CODE_W-1:0] XF_ROT_X270 = 4'd3;
    localparam logic [CODE_W-1:0] XF_ROT_Y90  = 4'd4;
    localparam logic [CODE_W-1:0] XF_ROT_Y180 = 4'd5;
    localparam logic [CODE_W-1:0] XF_ROT_Y270 = 4'd6;
    localparam logic [CODE_W-1:0] XF_ROT_Z90  = 4'd7;
    localparam logic [CODE_W-1:0] XF_ROT_Z180 = 4'd8;
    localparam logic [CODE_W-1:0] XF_ROT_Z270 = 4'd9;
    localparam logic [CODE_W-1:0] XF_FLIP_X   = 4'd10;
    localparam logic [CODE_W-1:0] XF_FLIP_Y   = 4'd11;
    localparam logic [CODE_W-1:0] XF_FLIP_Z   = 4'd12;

    typedef enum logic [1:0] {
        PERM_XYZ,
        PERM_XZY,
        PERM_ZYX,
        PERM_YXZ
    } perm_t;

    // Bit i of flip selects a flip of axis i (0 = x, 1 = y, 2 = z).
    typedef struct packed {
        perm_t      perm;
        logic [2:0] flip;
    } xform_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic xform_t xform_lookup(input logic [CODE_W-1:0] code);
        xform_t xf;
        xf = '{perm: PERM_XYZ, flip: 3'b000};
        unique case (code)
            XF_ROT_X90:  xf = '{perm: PERM_XZY, flip: 3'b100};
            XF_ROT_X180: xf = '{perm: PERM_XYZ, flip: 3'b110};
            XF_ROT_X270: xf = '{perm: PERM_XZY, flip: 3'b010};
            XF_ROT_Y90:  xf = '{perm: PERM_ZYX, flip: 3'b001};
            XF_ROT_Y180: xf = '{perm: PERM_XYZ, flip: 3'b101};
            XF_ROT_Y270: xf = '{perm: PERM_ZYX, flip: 3'b100};
            XF_ROT_Z90:  xf = '{perm: PERM_YXZ, flip: 3'b010};
            XF_ROT_Z180: xf = '{perm: PERM_XYZ, flip: 3'b011};
            XF_ROT_Z270: xf = '{perm: PERM_YXZ, flip: 3'b001};
            XF_FLIP_X:   xf = '{perm: PERM_XYZ, flip: 3'b001};
            XF_FLIP_Y:   xf = '{perm: PERM_XYZ, flip: 3'b010};
            XF_FLIP_Z:   xf = '{perm: PERM_XYZ, flip: 3'b100};
            default:     xf = '{perm: PERM_XYZ, flip: 3'b000};
        endcase
        return xf;
    endfunction

    // Source axis that lands at destination axis pos under the permutation.
    function automatic logic [1:0] perm_src(input perm_t perm, input logic [1:0] pos);
        logic [1:0] src;
        src = pos;
        unique case (perm)
            PERM_XZY: src = (pos == 2'd1) ? 2'd2 : ((pos == 2'd2) ? 2'd1 : pos);
            PERM_ZYX: src = (pos == 2'd0) ? 2'd2 : ((pos == 2'd2) ? 2'd0 : pos);
            PERM_YXZ: src = (pos == 2'd0) ? 2'd1 : ((pos == 2'd1) ? 2'd0 : pos);
            default:  src = pos;
        endcase
        return src;
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] e;
        e = d;
        if (d == '0)
        begin
            e = DIM_W'(1);
        end
        else if (d > MAX_DIM)
        begin
            e = MAX_DIM;
        end
        return e;
    endfunction

endpackage

### rtl/vvrf_ctrl.sv
`include "assert_macros.svh"

module vvrf_ctrl
    import vvrf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    assign in_ready     = ready_reg;
    assign cmd.accept   = ready_reg && in_valid;
    assign cmd.mul      = (state_reg == ST_MUL);
    assign cmd.load_out = (state_reg == ST_ADD) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_MUL;
                    ready_next = 1'b0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    `ASSERT_NEXT(a_accept_to_mul, clk, rst_n, cmd.accept, state_reg == ST_MUL)
    `ASSERT_NEXT(a_mul_to_add, clk, rst_n, state_reg == ST_MUL, state_reg == ST_ADD)
    `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !ready_reg)
    `ASSERT_NEXT(a_load_frees, clk, rst_n, cmd.load_out, ready_reg && state_reg == ST_IDLE)

endmodule

### rtl/vvrf_datapath.sv
`include "assert_macros.svh"

module vvrf_datapath
    import vvrf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic [IN_DATA_W-1:0]    in_data,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_DATA_W-1:0]   out_data,
    output logic                    out_last
);

    logic [DIM_W-1:0]   dim_reg [3];
    logic [COORD_W-1:0] anchor_reg [3];
    logic [CODE_W-1:0]  code_reg;
    logic [COORD_W-1:0] cnt_reg [3];
    logic [COORD_W-1:0] cnt_next [3];

    logic [DIM_W-1:0]   dims [3];
    logic [DIM_W-1:0]   nd_c [3];
    logic [IDX_W-1:0]   fc [3];
    logic [IDX_W-1:0]   pc_c [3];
    logic [COORD_W-1:0] fa [3];
    logic [COORD_W-1:0] pa_c [3];
    logic [2:0]         at_end;
    logic               last_c;
    xform_t             xf;

    logic [PLANE_W-1:0] plane_reg;
    logic [IDX_W-1:0]   pc_reg [3];
    logic [DIM_W-1:0]   nd_reg [3];
    logic [COORD_W-1:0] pa_reg [3];
    logic [VOXEL_W-1:0] voxel_reg;
    logic               last_reg;
    logic [IDX_W-1:0]   t0_reg;
    logic [IDX_W-1:0]   t1_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   o_idx_reg;
    logic [VOXEL_W-1:0] o_voxel_reg;
    logic               o_last_reg;
    logic [DIM_W-1:0]   o_dim_reg [3];
    logic [COORD_W-1:0] o_anchor_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg[0]    <= DIM_W'(1);
            dim_reg[1]    <= DIM_W'(1);
            dim_reg[2]    <= DIM_W'(1);
            anchor_reg[0] <= '0;
            anchor_reg[1] <= '0;
            anchor_reg[2] <= '0;
            code_reg      <= XF_IDENTITY;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIM_X:     dim_reg[0]    <= cfg_data;
                REG_DIM_Y:     dim_reg[1]    <= cfg_data;
                REG_DIM_Z:     dim_reg[2]    <= cfg_data;
                REG_ANCHOR_X:  anchor_reg[0] <= cfg_data[COORD_W-1:0];
                REG_ANCHOR_Y:  anchor_reg[1] <= cfg_data[COORD_W-1:0];
                REG_ANCHOR_Z:  anchor_reg[2] <= cfg_data[COORD_W-1:0];
                REG_TRANSFORM: code_reg      <= cfg_data[CODE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        xf = xform_lookup(code_reg);
        for (int i = 0; i < 3; i++)
        begin
            dims[i]   = eff_dim(dim_reg[i]);
            at_end[i] = ({1'b0, cnt_reg[i]} + DIM_W'(1)) >= dims[i];
            fc[i] = xf.flip[i] ? (IDX_W'(dims[i]) - IDX_W'(1) - IDX_W'(cnt_reg[i]))
                               : IDX_W'(cnt_reg[i]);
            fa[i] = xf.flip[i]
                ? COORD_W'(dims[i] - DIM_W'(1) - {1'b0, anchor_reg[i]})
                : anchor_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            nd_c[i] = dims[perm_src(xf.perm, 2'(i))];
            pc_c[i] = fc[perm_src(xf.perm, 2'(i))];
            pa_c[i] = fa[perm_src(xf.perm, 2'(i))];
        end
        last_c = &at_end;

        cnt_next[0] = cnt_reg[0];
        cnt_next[1] = cnt_reg[1];
        cnt_next[2] = cnt_reg[2];
        if (!at_end[2])
        begin
            cnt_next[2] = cnt_reg[2] + COORD_W'(1);
        end
        else
        begin
            cnt_next[2] = '0;
            if (!at_end[1])
            begin
                cnt_next[1] = cnt_reg[1] + COORD_W'(1);
            end
            else
            begin
                cnt_next[1] = '0;
                cnt_next[0] = at_end[0] ? '0 : cnt_reg[0] + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            cnt_reg[2] <= '0;
        end
        else if (cmd.accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg <= PLANE_W'(nd_c[1]) * PLANE_W'(nd_c[2]);
        if (cmd.accept)
        begin
            pc_reg    <= pc_c;
            nd_reg    <= nd_c;
            pa_reg    <= pa_c;
            voxel_reg <= in_data[VOXEL_W-1:0];
            last_reg  <= last_c;
        end
        if (cmd.mul)
        begin
            t1_reg <= pc_reg[1] * IDX_W'(nd_reg[2]);
            t0_reg <= pc_reg[0] * IDX_W'(plane_reg);
        end
        if (cmd.load_out)
        begin
            o_idx_reg    <= pc_reg[2] + t1_reg + t0_reg;
            o_voxel_reg  <= voxel_reg;
            o_last_reg   <= last_reg;
            o_dim_reg    <= nd_reg;
            o_anchor_reg <= pa_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_last  = o_last_reg;
    assign out_data  = {3'b000, o_anchor_reg[2], o_anchor_reg[1], o_anchor_reg[0],
                        o_dim_reg[2], o_dim_reg[1], o_dim_reg[0], o_voxel_reg, o_idx_reg};

    `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_out, out_valid_reg)
    `ASSERT_NEXT(a_last_wraps, clk, rst_n, cmd.accept && last_c,
        cnt_reg[0] == '0 && cnt_reg[1] == '0 && cnt_reg[2] == '0)
    `ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.load_out, status.out_free)

endmodule

### rtl/voxel_volume_rotate_flip.sv
// Voxel volume rotate and flip. Voxels enter on s_axis in source scan order (x outermost,
// z innermost); for each one a result leaves on m_axis with its linear index in the
// rotated or flipped volume, the new dimensions, the transformed anchor, and tlast on the
// final voxel of the volume. The controller steps each voxel through capture and flip at
// its input transfer, the two multiplies in the next cycle, and the final sum in the cycle
// after, which loads the result into the output register. s_axis_tready returns in the
// cycle after that load, so with no output stall a new voxel is accepted only once the
// previous one has loaded its result. While a result waits for m_axis_tready, one more
// voxel is still accepted and holds in its final-sum cycle until the output register frees.
// Registers are to be written over cfg only while no voxel is in flight; the user must keep
// to this, as the block itself does not enforce it.
module voxel_volume_rotate_flip
    import vvrf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0: block_value[9:0], zero fill.
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // Fields from bit 0: dest_index[23:0], voxel_out[33:24], new_dim_x[42:34],
    // new_dim_y[51:43], new_dim_z[60:52], new_anchor_x[68:61], new_anchor_y[76:69],
    // new_anchor_z[84:77], zero fill.
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                    m_axis_tlast
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    vvrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    vvrf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### tb/voxel_volume_rotate_flip_test.sv
`timescale 1ns / 1ps

module voxel_volume_rotate_flip_test;
    import vvrf_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int CODE_COUNT    = 1 << CODE_W;
    localparam int WHOLE_VOL_MAX = 512;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic [IDX_W-1:0]   dest_index;
        logic [VOXEL_W-1:0] voxel;
        logic               last;
        logic [DIM_W-1:0]   dim_x;
        logic [DIM_W-1:0]   dim_y;
        logic [DIM_W-1:0]   dim_z;
        logic [COORD_W-1:0] anchor_x;
        logic [COORD_W-1:0] anchor_y;
        logic [COORD_W-1:0] anchor_z;
    } voxel_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_VOXEL
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [VOXEL_W-1:0]    value;
        logic                  typed;
        logic [IDX_W-1:0]      dest_index;
        logic                  last;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    logic [DIM_W-1:0]   reg_dim [3];
    logic [COORD_W-1:0] reg_anchor [3];
    logic [CODE_W-1:0]  reg_code;
    int unsigned        src_pos [3];

    voxel_result_t pending_voxels [$];
    stim_row_t     directed_rows [$];
    voxel_result_t got_result;
    voxel_result_t want_result;
    int            mismatches;
    int            cycle_count;
    int            stall_left;
    bit            quiet;

    voxel_volume_rotate_flip i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] d);
        if (d == '0)
        begin
            return 32'd1;
        end
        else if (d > MAX_DIM)
        begin
            return 32'(MAX_DIM);
        end
        return 32'(d);
    endfunction

    function automatic xform_t route_of(input logic [CODE_W-1:0] code);
        xform_t xf;
        xf.perm = PERM_XYZ;
        xf.flip = 3'b000;
        case (code)
            XF_ROT_X90:  begin xf.perm = PERM_XZY; xf.flip = 3'b100; end
            XF_ROT_X180: begin xf.perm = PERM_XYZ; xf.flip = 3'b110; end
            XF_ROT_X270: begin xf.perm = PERM_XZY; xf.flip = 3'b010; end
            XF_ROT_Y90:  begin xf.perm = PERM_ZYX; xf.flip = 3'b001; end
            XF_ROT_Y180: begin xf.perm = PERM_XYZ; xf.flip = 3'b101; end
            XF_ROT_Y270: begin xf.perm = PERM_ZYX; xf.flip = 3'b100; end
            XF_ROT_Z90:  begin xf.perm = PERM_YXZ; xf.flip = 3'b010; end
            XF_ROT_Z180: begin xf.perm = PERM_XYZ; xf.flip = 3'b011; end
            XF_ROT_Z270: begin xf.perm = PERM_YXZ; xf.flip = 3'b001; end
            XF_FLIP_X:   begin xf.perm = PERM_XYZ; xf.flip = 3'b001; end
            XF_FLIP_Y:   begin xf.perm = PERM_XYZ; xf.flip = 3'b010; end
            XF_FLIP_Z:   begin xf.perm = PERM_XYZ; xf.flip = 3'b100; end
            default:     begin xf.perm = PERM_XYZ; xf.flip = 3'b000; end
        endcase
        return xf;
    endfunction

    function automatic vec3_t swap_axes(input perm_t perm, input vec3_t v);
        vec3_t r;
        r = v;
        case (perm)
            PERM_XZY: begin r[1] = v[2]; r[2] = v[1]; end
            PERM_ZYX: begin r[0] = v[2]; r[2] = v[0]; end
            PERM_YXZ: begin r[0] = v[1]; r[1] = v[0]; end
            default:  r = v;
        endcase
        return r;
    endfunction

    function automatic vec3_t place(input xform_t xf, input vec3_t dims, input vec3_t v);
        vec3_t r;
        r = v;
        for (int i = 0; i < 3; i++)
        begin
            if (xf.flip[i])
            begin
                r[i] = dims[i] - 32'd1 - v[i];
            end
        end
        return swap_axes(xf.perm, r);
    endfunction

    // Also advances the source scan position, so it is called once per accepted voxel.
    function automatic voxel_result_t predict_voxel(input logic [VOXEL_W-1:0] value);
        xform_t        xf;
        vec3_t         dims;
        vec3_t         nd;
        vec3_t         c;
        vec3_t         a;
        logic [31:0]   idx;
        logic [2:0]    at_end;
        voxel_result_t r;
        for (int i = 0; i < 3; i++)
        begin
            dims[i]   = clamp_dim(reg_dim[i]);
            c[i]      = src_pos[i];
            a[i]      = 32'(reg_anchor[i]);
            at_end[i] = (src_pos[i] + 32'd1 >= dims[i]);
        end
        xf  = route_of(reg_code);
        nd  = swap_axes(xf.perm, dims);
        c   = place(xf, dims, c);
        a   = place(xf, dims, a);
        idx = c[2] + c[1] * nd[2] + c[0] * (nd[1] * nd[2]);
        r.dest_index = idx[IDX_W-1:0];
        r.voxel      = value;
        r.last       = &at_end;
        r.dim_x      = nd[0][DIM_W-1:0];
        r.dim_y      = nd[1][DIM_W-1:0];
        r.dim_z      = nd[2][DIM_W-1:0];
        r.anchor_x   = a[0][COORD_W-1:0];
        r.anchor_y   = a[1][COORD_W-1:0];
        r.anchor_z   = a[2][COORD_W-1:0];
        if (!at_end[2])
        begin
            src_pos[2]++;
        end
        else
        begin
            src_pos[2] = 0;
            if (!at_end[1])
            begin
                src_pos[1]++;
            end
            else
            begin
                src_pos[1] = 0;
                src_pos[0] = at_end[0] ? 0 : src_pos[0] + 1;
            end
        end
        return r;
    endfunction

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        stim_row_t row;
        row = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_data  = CFG_DATA_W'(data);
        directed_rows.push_back(row);
    endtask

    task automatic add_voxel(input int value, input bit typed, input int dest, input bit last);
        stim_row_t row;
        row = '0;
        row.kind       = ROW_VOXEL;
        row.value      = VOXEL_W'(value);
        row.typed      = typed;
        row.dest_index = IDX_W'(dest);
        row.last       = last;
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DIM_X:     reg_dim[0] = data;
            REG_DIM_Y:     reg_dim[1] = data;
            REG_DIM_Z:     reg_dim[2] = data;
            REG_ANCHOR_X:  reg_anchor[0] = data[COORD_W-1:0];
            REG_ANCHOR_Y:  reg_anchor[1] = data[COORD_W-1:0];
            REG_ANCHOR_Z:  reg_anchor[2] = data[COORD_W-1:0];
            REG_TRANSFORM: reg_code = data[CODE_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_voxel(input logic [VOXEL_W-1:0] value, input bit typed,
                              input logic [IDX_W-1:0] dest, input bit last);
        voxel_result_t r;
        int            gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(value);
        do @(posedge clk); while (!s_axis_tready);
        r = predict_voxel(value);
        if (typed)
        begin
            r.dest_index = dest;
            r.last       = last;
        end
        pending_voxels.push_back(r);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_voxels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic show_result(input string label, input voxel_result_t r);
        $display("  %s idx %0d voxel %0d last %0b dims %0d/%0d/%0d anchor %0d/%0d/%0d",
                 label, r.dest_index, r.voxel, r.last, r.dim_x, r.dim_y, r.dim_z,
                 r.anchor_x, r.anchor_y, r.anchor_z);
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result.dest_index = m_axis_tdata[23:0];
            got_result.voxel      = m_axis_tdata[33:24];
            got_result.dim_x      = m_axis_tdata[42:34];
            got_result.dim_y      = m_axis_tdata[51:43];
            got_result.dim_z      = m_axis_tdata[60:52];
            got_result.anchor_x   = m_axis_tdata[68:61];
            got_result.anchor_y   = m_axis_tdata[76:69];
            got_result.anchor_z   = m_axis_tdata[84:77];
            got_result.last       = m_axis_tlast;
            if (pending_voxels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("Result transfer with nothing pending at %0t.", $realtime);
                    show_result("actual  ", got_result);
                end
            end
            else
            begin
                want_result = pending_voxels.pop_front();
                if (got_result.dest_index !== want_result.dest_index
                    || got_result.voxel !== want_result.voxel
                    || got_result.last !== want_result.last
                    || got_result.dim_x !== want_result.dim_x
                    || got_result.dim_y !== want_result.dim_y
                    || got_result.dim_z !== want_result.dim_z
                    || got_result.anchor_x !== want_result.anchor_x
                    || got_result.anchor_y !== want_result.anchor_y
                    || got_result.anchor_z !== want_result.anchor_z)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("Result mismatch at %0t.", $realtime);
                        show_result("expected", want_result);
                        show_result("actual  ", got_result);
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int               items_sent;
        int               shape;
        int               axis;
        int               count;
        longint           vol;
        longint           pos;
        longint           remaining;
        longint           d [3];
        logic [DIM_W-1:0] new_dim [3];
        bit               streaming;
        bit               in_range;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        streaming     = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            reg_dim[i]    = DIM_W'(1);
            reg_anchor[i] = '0;
            src_pos[i]    = 0;
        end
        reg_code = XF_IDENTITY;

        // A 1x1x1 volume after reset: every voxel is the last one.
        add_voxel(0, 1'b1, 0, 1'b1);
        add_voxel(1023, 1'b1, 0, 1'b1);
        add_write(REG_DIM_X, 256);
        add_write(REG_TRANSFORM, XF_FLIP_X);
        add_voxel($urandom_range(0, 1023), 1'b1, 255, 1'b0);
        add_voxel($urandom_range(0, 1023), 1'b1, 254, 1'b0);
        // Shrinking x leaves the x counter past the new size.
        add_write(REG_DIM_X, 2);
        add_write(REG_DIM_Y, 3);
        add_write(REG_DIM_Z, 4);
        add_write(REG_ANCHOR_X, 255);
        add_write(REG_ANCHOR_Y, 7);
        add_write(REG_ANCHOR_Z, 200);
        for (int k = 0; k < CODE_COUNT; k++)
        begin
            add_write(REG_TRANSFORM, k);
            add_voxel($urandom_range(0, 1023), 1'b0, 0, 1'b0);
        end
        // Zero and oversized sizes are clamped.
        add_write(REG_DIM_X, 0);
        add_write(REG_DIM_Y, 511);
        add_write(REG_DIM_Z, 300);
        add_write(REG_TRANSFORM, XF_ROT_Y90);
        add_voxel($urandom_range(0, 1023), 1'b0, 0, 1'b0);
        add_voxel($urandom_range(0, 1023), 1'b0, 0, 1'b0);
        add_write(REG_DIM_X, 1);
        add_write(REG_DIM_Y, 1);
        add_write(REG_DIM_Z, 1);
        add_voxel($urandom_range(0, 1023), 1'b0, 0, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                if (streaming)
                begin
                    drain();
                    streaming = 1'b0;
                end
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else
            begin
                send_voxel(directed_rows[i].value, directed_rows[i].typed,
                           directed_rows[i].dest_index, directed_rows[i].last);
                streaming = 1'b1;
            end
        end

        while (items_sent < RANDOM_ITEMS)
        begin
            drain();
            shape = $urandom_range(0, 99);
            for (int i = 0; i < 3; i++)
            begin
                new_dim[i] = DIM_W'(1);
            end
            if (shape < 70)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    new_dim[i] = DIM_W'($urandom_range(0, 4) == 0 ? $urandom_range(1, 8)
                                                                  : $urandom_range(1, 4));
                end
            end
            else if (shape < 80)
            begin
                axis = $urandom_range(0, 2);
                new_dim[axis] = MAX_DIM;
            end
            else if (shape < 90)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    new_dim[i] = DIM_W'($urandom_range(0, 511));
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    new_dim[i] = DIM_W'($urandom_range(200, 256));
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    write_reg(CFG_IDX_W'(REG_DIM_X + i), new_dim[i]);
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    write_reg(CFG_IDX_W'(REG_ANCHOR_X + i), CFG_DATA_W'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 4) != 0)
            begin
                write_reg(REG_TRANSFORM, CFG_DATA_W'($urandom_range(0, CODE_COUNT - 1)));
            end

            in_range = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = longint'(clamp_dim(reg_dim[i]));
                if (longint'(src_pos[i]) >= d[i])
                begin
                    in_range = 1'b0;
                end
            end
            vol = d[0] * d[1] * d[2];
            pos = longint'(src_pos[0]) * d[1] * d[2] + longint'(src_pos[1]) * d[2]
                  + longint'(src_pos[2]);
            if (shape < 80 && in_range && vol <= longint'(WHOLE_VOL_MAX))
            begin
                remaining = vol - pos;
                if ($urandom_range(0, 9) == 0 && remaining > 1)
                begin
                    count = $urandom_range(1, int'(remaining) - 1);
                end
                else
                begin
                    count = int'(remaining);
                    if (vol <= 64 && $urandom_range(0, 1) == 1)
                    begin
                        count += int'(vol);
                    end
                end
            end
            else
            begin
                count = $urandom_range(1, 30);
            end
            if (count > RANDOM_ITEMS - items_sent)
            begin
                count = RANDOM_ITEMS - items_sent;
            end

            quiet = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < count; n++)
            begin
                send_voxel(VOXEL_W'($urandom_range(0, 1023)), 1'b0, '0, 1'b0);
                items_sent++;
                if ($urandom_range(0, 99) == 0)
                begin
                    drain();
                end
            end
            quiet = 1'b0;
        end

        drain();
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### voxel_volume_rotate_flip.f
+incdir+rtl
rtl/vvrf_pkg.sv
rtl/vvrf_ctrl.sv
rtl/vvrf_datapath.sv
rtl/voxel_volume_rotate_flip.sv
tb/voxel_volume_rotate_flip_test.sv
